// File: rtl/core/pbc_pkg.sv
// PRINCE cipher package: key base constants, round constants, M' matrix rows,
// S-box tables and the layer functions used by the cipher datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package pbc_pkg;

    localparam int unsigned BLOCK_W = 64;
    localparam int unsigned CFG_IDX_W = 1;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_KEY_SEED = 1'b0;
    localparam t_cfg_idx CFG_DECRYPT_MODE = 1'b1;

    localparam t_block K0_BASE = 64'h0011_2233_4455_6677;
    localparam t_block K1_BASE = 64'h8899_AABB_CCDD_EEFF;
    localparam t_block ALPHA = 64'hC0AC_29B7_C97C_50DD;
    localparam t_block SHIFT_COL_SEL = 64'hF000_F000_F000_F000;

    localparam t_block RCON [12] = '{
        64'h0000000000000000, 64'h13198a2e03707344,
        64'ha4093822299f31d0, 64'h082efa98ec4e6c89,
        64'h452821e638d01377, 64'hbe5466cf34e90c6c,
        64'h7ef84f78fd955cb1, 64'h85840851f1ac43aa,
        64'hc882d32f25323c54, 64'h64a51195e0e3610d,
        64'hd3b5a399ca0c2399, 64'hc0ac29b7c97c50dd
    };

    localparam logic [15:0] MAT_A [16] = '{
        16'h0111, 16'h2220, 16'h4404, 16'h8088, 16'h1011, 16'h0222, 16'h4440, 16'h8808,
        16'h1101, 16'h2022, 16'h0444, 16'h8880, 16'h1110, 16'h2202, 16'h4044, 16'h0888
    };

    localparam logic [15:0] MAT_B [16] = '{
        16'h1110, 16'h2202, 16'h4044, 16'h0888, 16'h0111, 16'h2220, 16'h4404, 16'h8088,
        16'h1011, 16'h0222, 16'h4440, 16'h8808, 16'h1101, 16'h2022, 16'h0444, 16'h8880
    };

    localparam logic [3:0] SBOX_FWD [16] = '{
        4'hb, 4'hf, 4'h3, 4'h2, 4'ha, 4'hc, 4'h9, 4'h1,
        4'h6, 4'h7, 4'h8, 4'h0, 4'he, 4'h5, 4'hd, 4'h4
    };

    localparam logic [3:0] SBOX_INV [16] = '{
        4'hb, 4'h7, 4'h3, 4'h2, 4'hf, 4'hd, 4'h8, 4'h9,
        4'ha, 4'h6, 4'h4, 4'h0, 4'h5, 4'he, 4'hc, 4'h1
    };

    // k0' = (k0 ror 1) ^ (k0 >> 63)
    function automatic t_block key_prime(input t_block k);
        t_block r;
        r = {k[0], k[63:1]};
        r[0] = r[0] ^ k[63];
        return r;
    endfunction

    function automatic t_block sub_fwd(input t_block x);
        t_block r;
        for (int i = 0; i < 16; i++) begin
            r[i*4 +: 4] = SBOX_FWD[x[i*4 +: 4]];
        end
        return r;
    endfunction

    function automatic t_block sub_inv(input t_block x);
        t_block r;
        for (int i = 0; i < 16; i++) begin
            r[i*4 +: 4] = SBOX_INV[x[i*4 +: 4]];
        end
        return r;
    endfunction

    function automatic logic [15:0] mat16(input logic [15:0] x, input logic use_b);
        logic [15:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (x[i]) begin
                r = r ^ (use_b ? MAT_B[i] : MAT_A[i]);
            end
        end
        return r;
    endfunction

    function automatic t_block m_prime(input t_block x);
        return {mat16(x[63:48], 1'b0), mat16(x[47:32], 1'b1),
                mat16(x[31:16], 1'b1), mat16(x[15:0], 1'b0)};
    endfunction

    // row i rotates left by 16*i
    function automatic t_block shift_rows(input t_block x);
        t_block r;
        t_block row;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            row = x & (SHIFT_COL_SEL >> (4 * i));
            r = r | (row << (16 * i)) | (row >> (64 - 16 * i));
        end
        return r;
    endfunction

    // row i rotates right by 16*i
    function automatic t_block inv_shift_rows(input t_block x);
        t_block r;
        t_block row;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            row = x & (SHIFT_COL_SEL >> (4 * i));
            r = r | (row >> (16 * i)) | (row << (64 - 16 * i));
        end
        return r;
    endfunction

endpackage

// File: rtl/core/pbc_addr_if.sv
// Input channel of the PRINCE block: valid/ready plus the line address.
// Depends on pbc_pkg.
`timescale 1ns / 1ps

interface pbc_addr_if;
    logic valid;
    logic ready;
    pbc_pkg::t_block line_address;

    modport source (output valid, output line_address, input ready);
    modport sink (input valid, input line_address, output ready);
endinterface

// File: rtl/core/pbc_block_if.sv
// Output channel of the PRINCE block: valid/ready plus the cipher block.
// Depends on pbc_pkg.
`timescale 1ns / 1ps

interface pbc_block_if;
    logic valid;
    logic ready;
    pbc_pkg::t_block cipher_block;

    modport source (output valid, output cipher_block, input ready);
    modport sink (input valid, input cipher_block, output ready);
endinterface

// File: rtl/core/prince_block_cipher.sv
// PRINCE 64-bit block cipher top level: key registers, input register,
// unrolled cipher rounds and result register.
// Depends on pbc_pkg, pbc_addr_if, pbc_block_if.
//
//  channel   dir  handshake     payload
//  i_addr    in   valid/ready   line_address [63:0]
//  o_block   out  valid/ready   cipher_block [63:0]
//  i_cfg_*   in   write enable  index [0:0], data [63:0]
//
// An accepted item passes the input register, then the result register; one item
// per cycle sustained while output ready stays high. Throughput is set by the single
// pass through the unrolled rounds between the input register and the result register.
// Synchronous active-low reset clears the valid bits and loads the default key.
// A stalled result holds the result register; input ready drops only when both
// registers are full and output ready is low.
`timescale 1ns / 1ps

module prince_block_cipher (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    pbc_addr_if.sink                i_addr,
    pbc_block_if.source             o_block,
    input  logic                    i_cfg_we,
    input  pbc_pkg::t_cfg_idx       i_cfg_index,
    input  pbc_pkg::t_block         i_cfg_data
);

    pbc_pkg::t_block r_k0;
    pbc_pkg::t_block r_k0p;
    pbc_pkg::t_block r_k1;
    logic            r_decrypt;

    pbc_pkg::t_block n_k0;
    pbc_pkg::t_block n_k1;

    logic            r_in_valid;
    pbc_pkg::t_block r_in_data;
    logic            r_out_valid;
    pbc_pkg::t_block r_out_data;

    logic            w_out_free;
    logic            w_in_free;

    pbc_pkg::t_block w_k1;
    pbc_pkg::t_block w_wa;
    pbc_pkg::t_block w_wb;
    pbc_pkg::t_block w_fwd [6];
    pbc_pkg::t_block w_inv [6];
    pbc_pkg::t_block n_out_data;

    assign n_k0 = pbc_pkg::K0_BASE + i_cfg_data;
    assign n_k1 = pbc_pkg::K1_BASE + i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k0      <= pbc_pkg::K0_BASE;
            r_k0p     <= pbc_pkg::key_prime(pbc_pkg::K0_BASE);
            r_k1      <= pbc_pkg::K1_BASE;
            r_decrypt <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pbc_pkg::CFG_KEY_SEED: begin
                    r_k0  <= n_k0;
                    r_k0p <= pbc_pkg::key_prime(n_k0);
                    r_k1  <= n_k1;
                end
                pbc_pkg::CFG_DECRYPT_MODE: begin
                    r_decrypt <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // decrypt: swap whitening keys, fold alpha into k1
    assign w_k1 = r_decrypt ? (r_k1 ^ pbc_pkg::ALPHA) : r_k1;
    assign w_wa = r_decrypt ? r_k0p : r_k0;
    assign w_wb = r_decrypt ? r_k0 : r_k0p;

    assign w_out_free = !r_out_valid || o_block.ready;
    assign w_in_free  = !r_in_valid || w_out_free;
    assign i_addr.ready = w_in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_free) begin
            r_in_valid <= i_addr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_free && i_addr.valid) begin
            r_in_data <= i_addr.line_address;
        end
    end

    assign w_fwd[0] = r_in_data ^ w_wa ^ w_k1 ^ pbc_pkg::RCON[0];

    for (genvar g = 1; g < 6; g++) begin : g_fwd
        assign w_fwd[g] = pbc_pkg::shift_rows(pbc_pkg::m_prime(pbc_pkg::sub_fwd(w_fwd[g-1])))
                        ^ w_k1 ^ pbc_pkg::RCON[g];
    end

    assign w_inv[0] = pbc_pkg::sub_inv(pbc_pkg::m_prime(pbc_pkg::sub_fwd(w_fwd[5])));

    for (genvar g = 1; g < 6; g++) begin : g_inv
        assign w_inv[g] = pbc_pkg::sub_inv(pbc_pkg::m_prime(
                              pbc_pkg::inv_shift_rows(w_inv[g-1] ^ w_k1 ^ pbc_pkg::RCON[g+5])));
    end

    assign n_out_data = w_inv[5] ^ w_k1 ^ pbc_pkg::RCON[11] ^ w_wb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_block.valid        = r_out_valid;
    assign o_block.cipher_block = r_out_data;

endmodule

// File: sim/prince_block_cipher_tb.sv
// Self-checking testbench for prince_block_cipher: random valid/ready traffic on both
// channels, key seed and decrypt mode changes between phases, per-item cipher prediction.
// Depends on pbc_pkg, pbc_addr_if, pbc_block_if and the prince_block_cipher RTL.
`timescale 1ns / 1ps

module prince_block_cipher_tb;

    localparam pbc_pkg::t_block KEY0_FIXED = 64'h0011_2233_4455_6677;
    localparam pbc_pkg::t_block KEY1_FIXED = 64'h8899_AABB_CCDD_EEFF;
    localparam pbc_pkg::t_block ALPHA_REFL = 64'hC0AC_29B7_C97C_50DD;
    localparam pbc_pkg::t_block ROW0_MASK  = 64'hF000_F000_F000_F000;
    // nibble i of the table holds S[i]
    localparam logic [63:0] SB_FWD = 64'h4d5e_0876_19ca_23fb;
    localparam logic [63:0] SB_REV = 64'h1ce5_046a_98df_237b;
    // 16-bit row i of the matrix sits at bits [16i +: 16]
    localparam logic [255:0] MA_ROWS = {
        16'h0888, 16'h4044, 16'h2202, 16'h1110, 16'h8880, 16'h0444, 16'h2022, 16'h1101,
        16'h8808, 16'h4440, 16'h0222, 16'h1011, 16'h8088, 16'h4404, 16'h2220, 16'h0111
    };
    localparam logic [255:0] MB_ROWS = {
        16'h8880, 16'h0444, 16'h2022, 16'h1101, 16'h8808, 16'h4440, 16'h0222, 16'h1011,
        16'h8088, 16'h4404, 16'h2220, 16'h0111, 16'h0888, 16'h4044, 16'h2202, 16'h1110
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    pbc_pkg::t_cfg_idx cfg_index = pbc_pkg::CFG_KEY_SEED;
    pbc_pkg::t_block   cfg_data = '0;

    pbc_addr_if  addr_ch ();
    pbc_block_if blk_ch ();

    prince_block_cipher DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_addr      (addr_ch),
        .o_block     (blk_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pbc_pkg::t_block line_queue[$];
    pbc_pkg::t_block cipher_expect[$];
    pbc_pkg::t_block key_seed_now = '0;
    bit              decrypt_now = 1'b0;
    bit              gaps_on = 1'b1;
    int              drain_at = -1;
    int              n_issued = 0;
    int              n_checked = 0;
    int              n_decrypted = 0;
    int              n_settings = 1;
    int              mismatches = 0;
    pbc_pkg::t_block want_block;

    function automatic pbc_pkg::t_block round_const(input int r);
        case (r)
            0:       return 64'h0000000000000000;
            1:       return 64'h13198a2e03707344;
            2:       return 64'ha4093822299f31d0;
            3:       return 64'h082efa98ec4e6c89;
            4:       return 64'h452821e638d01377;
            5:       return 64'hbe5466cf34e90c6c;
            6:       return 64'h7ef84f78fd955cb1;
            7:       return 64'h85840851f1ac43aa;
            8:       return 64'hc882d32f25323c54;
            9:       return 64'h64a51195e0e3610d;
            10:      return 64'hd3b5a399ca0c2399;
            default: return 64'hc0ac29b7c97c50dd;
        endcase
    endfunction

    function automatic pbc_pkg::t_block sbox_layer(input pbc_pkg::t_block x, input bit inv);
        pbc_pkg::t_block r;
        logic [3:0] nib;
        for (int i = 0; i < 16; i++) begin
            nib = x[i*4 +: 4];
            r[i*4 +: 4] = inv ? SB_REV[nib*4 +: 4] : SB_FWD[nib*4 +: 4];
        end
        return r;
    endfunction

    function automatic logic [15:0] mat16(input logic [15:0] x, input logic [255:0] rows);
        logic [15:0] acc;
        acc = '0;
        for (int i = 0; i < 16; i++) begin
            if (x[i]) begin
                acc = acc ^ rows[i*16 +: 16];
            end
        end
        return acc;
    endfunction

    function automatic pbc_pkg::t_block m_layer(input pbc_pkg::t_block x);
        return {mat16(x[63:48], MA_ROWS), mat16(x[47:32], MB_ROWS),
                mat16(x[31:16], MB_ROWS), mat16(x[15:0], MA_ROWS)};
    endfunction

    // row i turns by 16*i bits: left going forward, right on the way back
    function automatic pbc_pkg::t_block rotate_rows(input pbc_pkg::t_block x, input bit inv);
        pbc_pkg::t_block r;
        pbc_pkg::t_block row;
        int n;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            row = x & (ROW0_MASK >> (4 * i));
            n = 16 * i;
            if (n == 0) begin
                r = r | row;
            end else if (inv) begin
                r = r | (row >> n) | (row << (64 - n));
            end else begin
                r = r | (row << n) | (row >> (64 - n));
            end
        end
        return r;
    endfunction

    function automatic pbc_pkg::t_block prince_cipher(input pbc_pkg::t_block blk,
                                                      input pbc_pkg::t_block seed,
                                                      input bit decrypt);
        pbc_pkg::t_block k0;
        pbc_pkg::t_block k0p;
        pbc_pkg::t_block k1;
        pbc_pkg::t_block w_in;
        pbc_pkg::t_block w_out;
        pbc_pkg::t_block s;
        k0 = KEY0_FIXED + seed;
        k1 = KEY1_FIXED + seed;
        k0p = {k0[0], k0[63:1]} ^ {63'b0, k0[63]};
        w_in = k0;
        w_out = k0p;
        if (decrypt) begin
            k1 = k1 ^ ALPHA_REFL;
            w_in = k0p;
            w_out = k0;
        end
        s = blk ^ w_in ^ k1 ^ round_const(0);
        for (int r = 1; r < 6; r++) begin
            s = rotate_rows(m_layer(sbox_layer(s, 1'b0)), 1'b0) ^ k1 ^ round_const(r);
        end
        s = sbox_layer(m_layer(sbox_layer(s, 1'b0)), 1'b1);
        for (int r = 6; r < 11; r++) begin
            s = sbox_layer(m_layer(rotate_rows(s ^ k1 ^ round_const(r), 1'b1)), 1'b1);
        end
        return s ^ k1 ^ round_const(11) ^ w_out;
    endfunction

    function automatic pbc_pkg::t_block pick_line();
        pbc_pkg::t_block v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v = pbc_pkg::t_block'($urandom_range(65535));
            1: v = pbc_pkg::t_block'(1) << $urandom_range(63);
            2: v = ~(pbc_pkg::t_block'(1) << $urandom_range(63));
            3: v = v & {$urandom, $urandom};
            4: v = v | {$urandom, $urandom};
            default: ;
        endcase
        return v;
    endfunction

    function automatic pbc_pkg::t_block pick_seed();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return -KEY0_FIXED;
            3: return 64'h8000_0000_0000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input pbc_pkg::t_block got,
                                   input pbc_pkg::t_block want);
        mismatches++;
        $display("[%0t] mismatch: %s got %h want %h", $realtime, what, got, want);
    endtask

    task automatic write_reg(input pbc_pkg::t_cfg_idx idx, input pbc_pkg::t_block data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == pbc_pkg::CFG_KEY_SEED) begin
            key_seed_now = data;
        end else begin
            decrypt_now = data[0];
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (line_queue.size() != 0 || addr_ch.valid || cipher_expect.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", cipher_expect.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            addr_ch.valid <= 1'b0;
            addr_ch.line_address <= '0;
        end else begin
            if (addr_ch.valid && addr_ch.ready) begin
                cipher_expect.push_back(prince_cipher(addr_ch.line_address, key_seed_now,
                                                      decrypt_now));
                if (decrypt_now) begin
                    n_decrypted++;
                end
            end
            if (!addr_ch.valid || addr_ch.ready) begin
                if (line_queue.size() != 0 && !(gaps_on && $urandom_range(99) < 22)
                        && !(n_issued == drain_at && cipher_expect.size() != 0)) begin
                    addr_ch.valid <= 1'b1;
                    addr_ch.line_address <= line_queue.pop_front();
                    n_issued++;
                end else begin
                    addr_ch.valid <= 1'b0;
                    addr_ch.line_address <= {$urandom, $urandom};
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blk_ch.ready <= 1'b0;
        end else begin
            if (blk_ch.valid && blk_ch.ready) begin
                if (cipher_expect.size() == 0) begin
                    report_mismatch("unexpected item", blk_ch.cipher_block, '0);
                end else begin
                    want_block = cipher_expect.pop_front();
                    n_checked++;
                    if (blk_ch.cipher_block !== want_block) begin
                        report_mismatch("cipher_block", blk_ch.cipher_block, want_block);
                    end
                end
            end
            blk_ch.ready <= !(gaps_on && $urandom_range(99) < 22);
        end
    end

    initial begin
        addr_ch.valid = 1'b0;
        addr_ch.line_address = '0;
        blk_ch.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset key, encrypt
        @(negedge i_clk);
        line_queue.push_back(64'h0);
        line_queue.push_back('1);
        line_queue.push_back(64'h1);
        line_queue.push_back(64'h8000_0000_0000_0000);
        line_queue.push_back(64'h5555_5555_5555_5555);
        line_queue.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        line_queue.push_back(64'h0123_4567_89AB_CDEF);
        line_queue.push_back(64'hFEDC_BA98_7654_3210);
        wait_idle();

        // largest seed, decrypt; feed back some ciphertexts to get plaintext round trips
        write_reg(pbc_pkg::CFG_KEY_SEED, '1);
        write_reg(pbc_pkg::CFG_DECRYPT_MODE, {$urandom, $urandom} | 64'h1);
        n_settings++;
        @(negedge i_clk);
        line_queue.push_back(prince_cipher(64'h0, '1, 1'b0));
        line_queue.push_back(prince_cipher('1, '1, 1'b0));
        line_queue.push_back(prince_cipher(64'h0000_0000_1234_5678, '1, 1'b0));
        line_queue.push_back(64'h0);
        line_queue.push_back('1);
        line_queue.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        line_queue.push_back(64'h0000_0000_FFFF_FFFF);
        line_queue.push_back(64'hFFFF_FFFF_0000_0000);
        wait_idle();

        // top bit of the seed only; decrypt register with junk above bit 0 (encrypt)
        write_reg(pbc_pkg::CFG_KEY_SEED, 64'h8000_0000_0000_0000);
        write_reg(pbc_pkg::CFG_DECRYPT_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
        n_settings++;
        @(negedge i_clk);
        line_queue.push_back(64'h0);
        line_queue.push_back('1);
        line_queue.push_back(64'h0F0F_0F0F_0F0F_0F0F);
        line_queue.push_back(64'hF0F0_F0F0_F0F0_F0F0);
        line_queue.push_back(64'h0000_0000_0000_0FFF);
        line_queue.push_back(64'h8000_0000_0000_0001);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(pbc_pkg::CFG_KEY_SEED, pick_seed());
            write_reg(pbc_pkg::CFG_DECRYPT_MODE, ph[0] ? ({$urandom, $urandom} | 64'h1)
                                                       : ({$urandom, $urandom} & ~64'h1));
            n_settings++;
            @(negedge i_clk);
            gaps_on = (ph != 2);
            if (ph == 1) begin
                drain_at = n_issued + 110;
            end
            for (int k = 0; k < 225; k++) begin
                line_queue.push_back(pick_line());
            end
            wait_idle();
        end
        gaps_on = 1'b1;
        repeat (8) @(negedge i_clk);

        if (cipher_expect.size() != 0) begin
            report_mismatch("results never returned",
                            pbc_pkg::t_block'(cipher_expect.size()), '0);
        end
        $display("checked %0d cipher blocks over %0d key settings, %0d of them decrypted,",
                 n_checked, n_settings, n_decrypted);
        $display("with random stalls on both channels, a gap-free phase and a full drain");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
